>>> hdl/mjar_pkg.sv
`timescale 1ns / 1ps

package mjar_pkg;

   // Journal geometry
   localparam int JOURNAL_ENTRIES = 16;
   localparam int MAP_ENTRIES     = 8;
   localparam int SLOT_W          = $clog2(JOURNAL_ENTRIES);

   // Field widths
   localparam int LOGICAL_W  = 16;
   localparam int PHYSICAL_W = 32;
   localparam int SEQ_W      = 32;

   // Logical pages below this limit land in the mapping table
   localparam logic [LOGICAL_W:0] MAP_LIMIT = (LOGICAL_W + 1)'(MAP_ENTRIES);

   // Command queue between front and back (depth is a power of two)
   localparam int QUEUE_DEPTH = 2;
   localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
   localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [0:0] {
      CMD_APPEND = 1'b0,
      CMD_REPLAY = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_APPEND = 2'd0,
      KIND_ENTRY  = 2'd1,
      KIND_EMPTY  = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_EMIT
   } back_state_type;

   // One queued command
   typedef struct packed {
      cmd_type                 cmd;
      logic [LOGICAL_W-1:0]    logical;
      logic [PHYSICAL_W-1:0]   physical;
   } item_type;

   // Head of the command queue as seen by the back end
   typedef struct packed {
      logic     valid;
      item_type item;
   } q_head_type;

   // One stored journal entry
   typedef struct packed {
      logic [SEQ_W-1:0]      seq;
      logic [LOGICAL_W-1:0]  logical;
      logic [PHYSICAL_W-1:0] physical;
   } entry_type;

   // One result item
   typedef struct packed {
      logic                  valid;
      kind_type              kind;
      logic                  full;
      logic [SEQ_W-1:0]      seq;
      logic [LOGICAL_W-1:0]  logical;
      logic [PHYSICAL_W-1:0] physical;
      logic                  in_range;
      logic                  last;
   } rsp_type;

endpackage

>>> hdl/mjar_front.sv
`timescale 1ns / 1ps

module mjar_front import mjar_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_cmd,
   input  logic [LOGICAL_W-1:0]  req_logical_page,
   input  logic [PHYSICAL_W-1:0] req_physical_page,
   output q_head_type            head,
   input  logic                  pop
);

   item_type            queue_ff [QUEUE_DEPTH];
   logic [Q_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]  count_ff, count_in;
   logic                push;
   item_type            new_item;

   // Accept and classify the command
   assign busy = (count_ff == Q_CNT_W'(QUEUE_DEPTH));
   assign push = start && !busy;

   always_comb begin
      new_item.cmd      = req_cmd ? CMD_REPLAY : CMD_APPEND;
      new_item.logical  = req_logical_page;
      new_item.physical = req_physical_page;
   end

   // Queue pointers and fill count
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + Q_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + Q_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + Q_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - Q_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_item;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.item  = queue_ff[rd_ptr_ff];

endmodule

>>> hdl/mjar_back.sv
`timescale 1ns / 1ps

module mjar_back import mjar_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  q_head_type head,
   output logic       pop,
   output rsp_type    rsp
);

   back_state_type              state_ff, state_in;
   logic [JOURNAL_ENTRIES-1:0]  valid_ff, valid_in;
   logic [SEQ_W-1:0]            seq_ctr_ff, seq_ctr_in;
   logic [SLOT_W-1:0]           scan_idx_ff;
   logic                        rd_valid_ff;
   logic [SLOT_W-1:0]           rd_idx_ff;
   entry_type                   rd_data_ff;
   logic                        best_found_ff;
   logic [SLOT_W-1:0]           best_idx_ff;
   entry_type                   best_entry_ff;
   rsp_type                     rsp_ff, rsp_in;

   entry_type                   entry_mem [JOURNAL_ENTRIES];

   logic                        free_found;
   logic [SLOT_W-1:0]           free_idx;
   logic                        cmp_hit;
   logic [JOURNAL_ENTRIES-1:0]  remaining;
   logic                        mem_we;
   logic                        mem_re;
   logic                        is_append;
   entry_type                   wr_entry;

   // Lowest free slot
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = JOURNAL_ENTRIES - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_found = 1'b1;
            free_idx   = SLOT_W'(i);
         end
      end
   end

   // Running minimum; strict compare keeps the lower slot on equal sequence
   assign cmp_hit = rd_valid_ff && valid_ff[rd_idx_ff] &&
                    (!best_found_ff || (rd_data_ff.seq < best_entry_ff.seq));

   assign remaining = valid_ff & ~(JOURNAL_ENTRIES'(1) << best_idx_ff);
   assign is_append = (head.item.cmd == CMD_APPEND);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (head.valid && !is_append && (valid_ff != '0)) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_idx_ff == SLOT_W'(JOURNAL_ENTRIES - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            state_in = (remaining != '0) ? ST_SCAN : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs of the sequencer
   always_comb begin
      pop        = 1'b0;
      mem_we     = 1'b0;
      mem_re     = 1'b0;
      valid_in   = valid_ff;
      seq_ctr_in = seq_ctr_ff;
      rsp_in     = '0;
      case (state_ff)
         ST_IDLE: begin
            pop = head.valid;
            if (head.valid) begin
               rsp_in.valid = 1'b1;
               rsp_in.last  = 1'b1;
               if (is_append) begin
                  rsp_in.kind = KIND_APPEND;
                  rsp_in.full = !free_found;
                  if (free_found) begin
                     mem_we             = 1'b1;
                     valid_in[free_idx] = 1'b1;
                     rsp_in.seq         = seq_ctr_ff;
                     seq_ctr_in         = seq_ctr_ff + SEQ_W'(1);
                  end
               end else if (valid_ff == '0) begin
                  rsp_in.kind = KIND_EMPTY;
               end else begin
                  // Replay proceeds through the scan, no result yet
                  rsp_in = '0;
               end
            end
         end
         ST_SCAN: begin
            mem_re = 1'b1;
         end
         ST_DRAIN: begin
         end
         ST_EMIT: begin
            valid_in        = remaining;
            rsp_in.valid    = 1'b1;
            rsp_in.kind     = KIND_ENTRY;
            rsp_in.seq      = best_entry_ff.seq;
            rsp_in.logical  = best_entry_ff.logical;
            rsp_in.physical = best_entry_ff.physical;
            rsp_in.in_range = ({1'b0, best_entry_ff.logical} < MAP_LIMIT);
            rsp_in.last     = (remaining == '0);
         end
         default: begin
         end
      endcase
   end

   // Control registers and the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         valid_ff      <= '0;
         seq_ctr_ff    <= '0;
         scan_idx_ff   <= '0;
         rd_valid_ff   <= 1'b0;
         best_found_ff <= 1'b0;
         rsp_ff.valid  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         seq_ctr_ff   <= seq_ctr_in;
         scan_idx_ff  <= (state_ff == ST_SCAN) ? scan_idx_ff + SLOT_W'(1) : '0;
         rd_valid_ff  <= mem_re;
         rsp_ff       <= rsp_in;
         if ((state_ff == ST_IDLE) || (state_ff == ST_EMIT)) begin
            best_found_ff <= 1'b0;
         end else if (cmp_hit) begin
            best_found_ff <= 1'b1;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rd_idx_ff <= scan_idx_ff;
      if (cmp_hit) begin
         best_idx_ff   <= rd_idx_ff;
         best_entry_ff <= rd_data_ff;
      end
   end

   // Entry memory: one write port, one registered read port
   always_comb begin
      wr_entry.seq      = seq_ctr_ff;
      wr_entry.logical  = head.item.logical;
      wr_entry.physical = head.item.physical;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[free_idx] <= wr_entry;
      end
      if (mem_re) begin
         rd_data_ff <= entry_mem[scan_idx_ff];
      end
   end

   assign rsp = rsp_ff;

endmodule

>>> hdl/mapping_journal_append_replay.sv
`timescale 1ns / 1ps

// Mapping journal with append and drain-replay.
// Command channel: an item (req_cmd, req_logical_page, req_physical_page) is
// taken at a clock edge with start high and busy low. busy rises only when the
// two-entry command queue is full.
// Result channel: rsp_valid marks each result for one cycle; there is no
// backpressure, the receiver must take every result as it appears.
// Append: one result per item; with the back end idle, appends sustain one per
// cycle (the queue pop and the journal update happen in the same cycle).
// Replay: the back end scans all JOURNAL_ENTRIES slots through the entry
// memory's single read port to find the oldest entry, once for each replayed
// entry; rsp_last marks the final one. An empty journal gives one result.
// Commands behind a replay wait in the queue until the replay finishes.
// Reset (synchronous, active high) empties the queue and the journal and
// clears the sequence counter; no clearing pass is needed.

module mapping_journal_append_replay import mjar_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_cmd,
   input  logic [LOGICAL_W-1:0]  req_logical_page,
   input  logic [PHYSICAL_W-1:0] req_physical_page,
   output logic                  rsp_valid,
   output logic [1:0]            rsp_kind,
   output logic                  rsp_journal_full,
   output logic [SEQ_W-1:0]      rsp_entry_seq,
   output logic [LOGICAL_W-1:0]  rsp_entry_logical,
   output logic [PHYSICAL_W-1:0] rsp_entry_physical,
   output logic                  rsp_in_map_range,
   output logic                  rsp_last
);

   q_head_type head;
   logic       pop;
   rsp_type    rsp;

   mjar_front u_front (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_cmd           (req_cmd),
      .req_logical_page  (req_logical_page),
      .req_physical_page (req_physical_page),
      .head              (head),
      .pop               (pop)
   );

   mjar_back u_back (
      .clock (clock),
      .reset (reset),
      .head  (head),
      .pop   (pop),
      .rsp   (rsp)
   );

   assign rsp_valid          = rsp.valid;
   assign rsp_kind           = rsp.kind;
   assign rsp_journal_full   = rsp.full;
   assign rsp_entry_seq      = rsp.seq;
   assign rsp_entry_logical  = rsp.logical;
   assign rsp_entry_physical = rsp.physical;
   assign rsp_in_map_range   = rsp.in_range;
   assign rsp_last           = rsp.last;

   // A replayed entry that is not the last is followed by a scan, not a result
   a_gap_after_entry: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |=> !rsp_valid)
      else $error("result right after a non-final replayed entry");

   // Only replayed entries can leave more results pending
   a_single_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && ((rsp_kind == KIND_APPEND) || (rsp_kind == KIND_EMPTY))) |-> rsp_last)
      else $error("append or empty result without last");

   // A dropped append carries no sequence number
   a_full_no_seq: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_journal_full) |-> ((rsp_kind == KIND_APPEND) && (rsp_entry_seq == '0)))
      else $error("full flag on a result that is not a dropped append");

   // The back end only pops a command that is waiting in the queue
   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid)
      else $error("pop from an empty command queue");

endmodule
